FILE: design/max_pool_window_argmax_unit_assert.svh
// Assertion macros used by the max pool window argmax unit checker.
`ifndef MAX_POOL_WINDOW_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOL_WINDOW_ARGMAX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MPWA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max_pool_window_argmax_unit: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MPWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max_pool_window_argmax_unit: assertion failed");

`endif

FILE: design/mpwa_pkg.sv
// Shared constants, codes and command/status types of the max pool window argmax unit.
package mpwa_pkg;

   localparam int MAX_PLANE_SIDE = 64;
   localparam int SIDE_W = $clog2(MAX_PLANE_SIDE);
   localparam int STORE_DEPTH = MAX_PLANE_SIDE * MAX_PLANE_SIDE;
   localparam int ADDR_W = 2 * SIDE_W;
   localparam int MAX_POOL = 8;
   localparam int POOL_CNT_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

   localparam int VALUE_W = 16;
   localparam int INDEX_W = 13;
   localparam int COORD_W = 12;

   localparam int PLANE_REG_W = 7;
   localparam int SIZE_REG_W = 4;
   localparam int PAD_REG_W = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_SIZE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_STRIDE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_AMOUNT = 3'd4;

   localparam logic [PLANE_REG_W-1:0] PLANE_WIDTH_RESET = 7'd64;
   localparam logic [PLANE_REG_W-1:0] PLANE_HEIGHT_RESET = 7'd64;
   localparam logic [SIZE_REG_W-1:0] POOL_SIZE_RESET = 4'd2;
   localparam logic [SIZE_REG_W-1:0] POOL_STRIDE_RESET = 4'd2;
   localparam logic [PAD_REG_W-1:0] PAD_AMOUNT_RESET = 3'd0;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_POOL = 1'b1;
   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_POOL = 1'b1;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = 16'sh8000;
   localparam logic signed [INDEX_W-1:0] EMPTY_INDEX = 13'sh1FFF;

   typedef struct packed {
      logic write_sample;
      logic load_window;
      logic scan_step;
      logic finish_pool;
   } cmd_type;

   typedef struct packed {
      logic last_position;
   } sts_type;

endpackage

FILE: design/mpwa_ram.sv
// Generic single-port RAM with registered read data.
module mpwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/mpwa_ctrl.sv
// Controller state machine that sequences sample writes and window scans.
module mpwa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_type,
   input  mpwa_pkg::sts_type sts,
   output mpwa_pkg::cmd_type cmd,
   output logic             busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start && req_type == mpwa_pkg::REQ_POOL) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               if (sts.last_position) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.write_sample = (state_ff == ST_IDLE) && start && (req_type == mpwa_pkg::REQ_WRITE);
      cmd.load_window  = (state_ff == ST_IDLE) && start && (req_type == mpwa_pkg::REQ_POOL);
      cmd.scan_step    = (state_ff == ST_SCAN);
      cmd.finish_pool  = (state_ff == ST_DRAIN);
   end

   assign busy = busy_ff;

endmodule

FILE: design/mpwa_datapath.sv
// Datapath: configuration registers, plane memory, window scan and running maximum.
module mpwa_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpwa_pkg::cmd_type                      cmd,
   output mpwa_pkg::sts_type                      sts,
   input  logic                                   csr_valid,
   input  logic [mpwa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mpwa_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic [mpwa_pkg::SIDE_W-1:0]            req_sample_x,
   input  logic [mpwa_pkg::SIDE_W-1:0]            req_sample_y,
   input  logic signed [mpwa_pkg::VALUE_W-1:0]    req_sample_value,
   input  logic [mpwa_pkg::SIDE_W-1:0]            req_out_x,
   input  logic [mpwa_pkg::SIDE_W-1:0]            req_out_y,
   output logic                                   rsp_valid,
   output logic                                   rsp_result_kind,
   output logic signed [mpwa_pkg::VALUE_W-1:0]    rsp_max_value,
   output logic signed [mpwa_pkg::INDEX_W-1:0]    rsp_max_index
);

   // Configuration registers.
   logic [mpwa_pkg::PLANE_REG_W-1:0] plane_width_ff;
   logic [mpwa_pkg::PLANE_REG_W-1:0] plane_height_ff;
   logic [mpwa_pkg::SIZE_REG_W-1:0]  pool_size_ff;
   logic [mpwa_pkg::SIZE_REG_W-1:0]  pool_stride_ff;
   logic [mpwa_pkg::PAD_REG_W-1:0]   pad_amount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_width_ff  <= mpwa_pkg::PLANE_WIDTH_RESET;
         plane_height_ff <= mpwa_pkg::PLANE_HEIGHT_RESET;
         pool_size_ff    <= mpwa_pkg::POOL_SIZE_RESET;
         pool_stride_ff  <= mpwa_pkg::POOL_STRIDE_RESET;
         pad_amount_ff   <= mpwa_pkg::PAD_AMOUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mpwa_pkg::CSR_PLANE_WIDTH:  plane_width_ff  <= csr_data;
            mpwa_pkg::CSR_PLANE_HEIGHT: plane_height_ff <= csr_data;
            mpwa_pkg::CSR_POOL_SIZE:    pool_size_ff    <= csr_data[mpwa_pkg::SIZE_REG_W-1:0];
            mpwa_pkg::CSR_POOL_STRIDE:  pool_stride_ff  <= csr_data[mpwa_pkg::SIZE_REG_W-1:0];
            mpwa_pkg::CSR_PAD_AMOUNT:   pad_amount_ff   <= csr_data[mpwa_pkg::PAD_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturated plane and window dimensions.
   logic [mpwa_pkg::PLANE_REG_W-1:0] width_sat;
   logic [mpwa_pkg::PLANE_REG_W-1:0] height_sat;
   logic [mpwa_pkg::SIZE_REG_W-1:0]  size_sat;
   logic [mpwa_pkg::POOL_CNT_W-1:0]  size_last;
   logic                             size_zero;

   always_comb begin
      width_sat  = (plane_width_ff > mpwa_pkg::PLANE_REG_W'(mpwa_pkg::MAX_PLANE_SIDE)) ?
                   mpwa_pkg::PLANE_REG_W'(mpwa_pkg::MAX_PLANE_SIDE) : plane_width_ff;
      height_sat = (plane_height_ff > mpwa_pkg::PLANE_REG_W'(mpwa_pkg::MAX_PLANE_SIDE)) ?
                   mpwa_pkg::PLANE_REG_W'(mpwa_pkg::MAX_PLANE_SIDE) : plane_height_ff;
      size_sat   = (pool_size_ff > mpwa_pkg::SIZE_REG_W'(mpwa_pkg::MAX_POOL)) ?
                   mpwa_pkg::SIZE_REG_W'(mpwa_pkg::MAX_POOL) : pool_size_ff;
      size_zero  = (size_sat == '0);
      size_last  = mpwa_pkg::POOL_CNT_W'(size_sat - mpwa_pkg::SIZE_REG_W'(1));
   end

   // Window origin, two's complement, latched when a pool transaction is taken.
   logic [mpwa_pkg::COORD_W-1:0]    x0_ff;
   logic [mpwa_pkg::COORD_W-1:0]    y0_ff;
   logic [mpwa_pkg::POOL_CNT_W-1:0] col_ff;
   logic [mpwa_pkg::POOL_CNT_W-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_window) begin
         x0_ff  <= mpwa_pkg::COORD_W'(req_out_x) * mpwa_pkg::COORD_W'(pool_stride_ff)
                   - mpwa_pkg::COORD_W'(pad_amount_ff);
         y0_ff  <= mpwa_pkg::COORD_W'(req_out_y) * mpwa_pkg::COORD_W'(pool_stride_ff)
                   - mpwa_pkg::COORD_W'(pad_amount_ff);
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.scan_step) begin
         if (col_ff == size_last) begin
            col_ff <= '0;
            row_ff <= row_ff + mpwa_pkg::POOL_CNT_W'(1);
         end else begin
            col_ff <= col_ff + mpwa_pkg::POOL_CNT_W'(1);
         end
      end
   end

   // Current window position and its validity.
   logic [mpwa_pkg::COORD_W-1:0] cur_x;
   logic [mpwa_pkg::COORD_W-1:0] cur_y;
   logic                         pos_valid;
   logic [mpwa_pkg::INDEX_W-1:0] pos_index;
   logic [mpwa_pkg::ADDR_W-1:0]  scan_addr;

   always_comb begin
      cur_x     = x0_ff + mpwa_pkg::COORD_W'(col_ff);
      cur_y     = y0_ff + mpwa_pkg::COORD_W'(row_ff);
      pos_valid = !size_zero
                  && !cur_x[mpwa_pkg::COORD_W-1] && (cur_x < mpwa_pkg::COORD_W'(width_sat))
                  && !cur_y[mpwa_pkg::COORD_W-1] && (cur_y < mpwa_pkg::COORD_W'(height_sat));
      pos_index = mpwa_pkg::INDEX_W'(cur_x[mpwa_pkg::SIDE_W-1:0])
                  + mpwa_pkg::INDEX_W'(width_sat)
                  * mpwa_pkg::INDEX_W'(cur_y[mpwa_pkg::SIDE_W-1:0]);
      scan_addr = {cur_y[mpwa_pkg::SIDE_W-1:0], cur_x[mpwa_pkg::SIDE_W-1:0]};
      sts.last_position = size_zero || (col_ff == size_last && row_ff == size_last);
   end

   // Plane memory, shared between sample writes and window reads.
   logic [mpwa_pkg::ADDR_W-1:0]  ram_addr;
   logic [mpwa_pkg::VALUE_W-1:0] ram_rdata;

   assign ram_addr = cmd.write_sample ? {req_sample_y, req_sample_x} : scan_addr;

   mpwa_ram #(
      .WIDTH (mpwa_pkg::VALUE_W),
      .DEPTH (mpwa_pkg::STORE_DEPTH)
   ) u_plane_ram (
      .clock (clock),
      .we    (cmd.write_sample),
      .addr  (ram_addr),
      .wdata (req_sample_value),
      .rdata (ram_rdata)
   );

   // Position tag that travels alongside the memory read.
   logic                         rd_valid_ff;
   logic [mpwa_pkg::INDEX_W-1:0] rd_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_step && pos_valid;
      end
      rd_index_ff <= pos_index;
   end

   // Running first strict maximum.
   logic                                found_ff;
   logic signed [mpwa_pkg::VALUE_W-1:0] best_value_ff;
   logic signed [mpwa_pkg::INDEX_W-1:0] best_index_ff;
   logic signed [mpwa_pkg::VALUE_W-1:0] rd_value;
   logic                                take;
   logic signed [mpwa_pkg::VALUE_W-1:0] best_value_in;
   logic signed [mpwa_pkg::INDEX_W-1:0] best_index_in;

   always_comb begin
      rd_value      = $signed(ram_rdata);
      take          = rd_valid_ff && (!found_ff || rd_value > best_value_ff);
      best_value_in = take ? rd_value : best_value_ff;
      best_index_in = take ? $signed(rd_index_ff) : best_index_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_window) begin
         found_ff      <= 1'b0;
         best_value_ff <= mpwa_pkg::EMPTY_VALUE;
         best_index_ff <= mpwa_pkg::EMPTY_INDEX;
      end else if (take) begin
         found_ff      <= 1'b1;
         best_value_ff <= best_value_in;
         best_index_ff <= best_index_in;
      end
   end

   // Result register.
   logic                                rsp_valid_ff;
   logic                                rsp_kind_ff;
   logic signed [mpwa_pkg::VALUE_W-1:0] rsp_value_ff;
   logic signed [mpwa_pkg::INDEX_W-1:0] rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.write_sample || cmd.finish_pool;
      end
      if (cmd.write_sample) begin
         rsp_kind_ff  <= mpwa_pkg::KIND_ACK;
         rsp_value_ff <= '0;
         rsp_index_ff <= '0;
      end else if (cmd.finish_pool) begin
         rsp_kind_ff  <= mpwa_pkg::KIND_POOL;
         rsp_value_ff <= best_value_in;
         rsp_index_ff <= best_index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_max_value   = rsp_value_ff;
   assign rsp_max_index   = rsp_index_ff;

endmodule

FILE: design/max_pool_window_argmax_unit.sv
// Top level of the max pool window argmax unit: controller plus datapath.
//
// This unit holds one 64 by 64 plane of signed Q8.8 samples and answers two kinds of
// transaction, both taken at a rising edge where start is high and busy is low. A write
// transaction (req_type 0) stores req_sample_value at (req_sample_x, req_sample_y) and is
// acknowledged in the next cycle; busy never rises for it, so writes can follow each other
// in every cycle. A pool transaction (req_type 1) scans the pool_size by pool_size window
// whose origin is (out_x * pool_stride - pad_amount, out_y * pool_stride - pad_amount),
// row by row, and reports the first strictly greatest sample inside the plane with its
// in-plane index x + plane_width * y, or -32768 and -1 when no window position lies in
// the plane. A pool transaction passes through a scan state and a drain state; the scan
// visits the s by s window positions, where s is pool_size saturated at eight (a single
// position when pool_size is zero), one per cycle through the single plane memory port,
// and the drain loads the result register. The result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, in the same cycle that busy falls, so a new
// transaction can be taken while the result is shown. The receiver cannot stall the
// unit: it must take each result as it is shown. Configuration is written through the
// csr_ channel, which is always ready, and must only be written while no pool
// transaction is in flight.

module max_pool_window_argmax_unit (
   input  logic                                clock,
   input  logic                                reset,

   // Request channel.
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [mpwa_pkg::SIDE_W-1:0]         req_sample_x,
   input  logic [mpwa_pkg::SIDE_W-1:0]         req_sample_y,
   input  logic signed [mpwa_pkg::VALUE_W-1:0] req_sample_value,
   input  logic [mpwa_pkg::SIDE_W-1:0]         req_out_x,
   input  logic [mpwa_pkg::SIDE_W-1:0]         req_out_y,

   // Response channel.
   output logic                                rsp_valid,
   output logic                                rsp_result_kind,
   output logic signed [mpwa_pkg::VALUE_W-1:0] rsp_max_value,
   output logic signed [mpwa_pkg::INDEX_W-1:0] rsp_max_index,

   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpwa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mpwa_pkg::CSR_DATA_W-1:0]     csr_data
);

   mpwa_pkg::cmd_type cmd;
   mpwa_pkg::sts_type sts;

   // Register writes go straight into the configuration registers, so the channel never pushes back.
   assign csr_ready = 1'b1;

   // The controller decides which transaction is taken and walks the window scan.
   mpwa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath owns the registers, the plane memory, the scan addressing and the
   // running maximum, and it drives the response register.
   mpwa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_sample_x     (req_sample_x),
      .req_sample_y     (req_sample_y),
      .req_sample_value (req_sample_value),
      .req_out_x        (req_out_x),
      .req_out_y        (req_out_y),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_index    (rsp_max_index)
   );

endmodule

FILE: design/mpwa_checker.sv
// Port-level checker for the max pool window argmax unit, with its bind.
`include "max_pool_window_argmax_unit_assert.svh"

module mpwa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_type,
   input logic                                rsp_valid,
   input logic                                rsp_result_kind,
   input logic signed [mpwa_pkg::VALUE_W-1:0] rsp_max_value,
   input logic signed [mpwa_pkg::INDEX_W-1:0] rsp_max_index
);

   logic write_taken;
   logic pool_taken;
   logic write_ack_shown;
   logic pool_result_shown;
   logic empty_index_shown;
   logic empty_value_shown;

   assign write_taken       = start && !busy && (req_type == mpwa_pkg::REQ_WRITE);
   assign pool_taken        = start && !busy && (req_type == mpwa_pkg::REQ_POOL);
   assign write_ack_shown   = rsp_valid && (rsp_result_kind == mpwa_pkg::KIND_ACK)
                              && (rsp_max_value == '0) && (rsp_max_index == '0);
   assign pool_result_shown = rsp_valid && (rsp_result_kind == mpwa_pkg::KIND_POOL);
   assign empty_index_shown = pool_result_shown && (rsp_max_index == mpwa_pkg::EMPTY_INDEX);
   assign empty_value_shown = (rsp_max_value == mpwa_pkg::EMPTY_VALUE);

   `MPWA_ASSERT_NEXT(write_acked_next_cycle, clock, reset, write_taken, write_ack_shown)
   `MPWA_ASSERT_NEXT(pool_raises_busy, clock, reset, pool_taken, busy && !rsp_valid)
   `MPWA_ASSERT_IMPLY(pool_result_ends_busy, clock, reset, pool_result_shown, !busy && $past(busy))
   `MPWA_ASSERT_IMPLY(empty_window_pairing, clock, reset, empty_index_shown, empty_value_shown)
   `MPWA_ASSERT_IMPLY(no_result_while_busy, clock, reset, busy, !rsp_valid)

endmodule

bind max_pool_window_argmax_unit mpwa_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_result_kind (rsp_result_kind),
   .rsp_max_value   (rsp_max_value),
   .rsp_max_index   (rsp_max_index)
);
